[rtl/gmc_pkg.sv]
// ----------------------------------------------------------------------------
// Grid maze carver package
// Shared sizes, command and status codes, cell and position types, and the
// request and response types of the remainder unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gmc_pkg;

  localparam int MAX_COLS = 32;
  localparam int MAX_ROWS = 32;
  localparam int CELLS    = MAX_COLS * MAX_ROWS;
  localparam int COL_W    = $clog2(MAX_COLS);
  localparam int ROW_W    = $clog2(MAX_ROWS);
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int MAX_DIM  = (MAX_COLS > MAX_ROWS) ? MAX_COLS : MAX_ROWS;
  localparam int DIM_W    = $clog2(MAX_DIM + 1);
  localparam int CMP_W    = (DIM_W > 7) ? DIM_W : 7;

  localparam int CMD_W      = 2;
  localparam int POS_W      = 5;
  localparam int RAND_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int DIR_W      = 2;
  localparam int WALL_W     = 4;
  localparam int CFG_DATA_W = 6;
  localparam int CFG_IDX_W  = 1;

  localparam int MOD_DIV_W  = 3;
  localparam int MOD_REM_W  = 2;
  localparam int BIT_CNT_W  = $clog2(RAND_W);

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CARVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_STARTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CARVED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DEAD    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OPEN    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_READ    = 3'd6;
  localparam logic [STATUS_W-1:0] ST_BAD     = 3'd7;

  localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;
  localparam logic [DIR_W-1:0] LEFT      = DIR_LEFT;
  localparam logic [DIR_W-1:0] DOWN      = DIR_DOWN;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] GRID_RESET = 6'd32;
  localparam logic [WALL_W-1:0]     WALLS_ALL  = 4'hF;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [CMP_W-1:0]  cmp_t;

  typedef struct packed {
    logic              visited;
    logic [WALL_W-1:0] walls;
  } cell_t;

  typedef struct packed {
    row_t row;
    col_t col;
  } pos_t;

  typedef struct packed {
    logic                 start;
    logic [RAND_W-1:0]    dividend;
    logic [MOD_DIV_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic                 done;
    logic [MOD_REM_W-1:0] rem;
  } mod_rsp_t;

  function automatic logic [DIR_W-1:0] opposite(logic [DIR_W-1:0] d);
    logic [DIR_W-1:0] o;
    case (d)
      DIR_UP:   o = DIR_DOWN;
      DIR_DOWN: o = DIR_UP;
      DIR_LEFT: o = DIR_RIGHT;
      default:  o = DIR_LEFT;
    endcase
    return o;
  endfunction

  function automatic addr_t cell_addr(pos_t p);
    return ADDR_W'(int'(p.row) * MAX_COLS + int'(p.col));
  endfunction

endpackage

[rtl/gmc_if.sv]
// ----------------------------------------------------------------------------
// Grid maze carver channels
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface gmc_in_if import gmc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [POS_W-1:0]  cell_row;
  logic [POS_W-1:0]  cell_col;
  logic [RAND_W-1:0] rand_value;

  modport source (output valid, cmd, cell_row, cell_col, rand_value, input ready);
  modport sink (input valid, cmd, cell_row, cell_col, rand_value, output ready);
endinterface

interface gmc_out_if import gmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    out_row;
  logic [POS_W-1:0]    out_col;
  logic [DIR_W-1:0]    direction;
  logic [WALL_W-1:0]   wall_bits;
  logic                visited;

  modport source (output valid, status, out_row, out_col, direction, wall_bits, visited,
                  input ready);
  modport sink (input valid, status, out_row, out_col, direction, wall_bits, visited,
                output ready);
endinterface

interface gmc_cfg_if import gmc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/gmc_mod_unit.sv]
// ----------------------------------------------------------------------------
// Grid maze carver remainder unit
// Bit-serial restoring remainder of the random word by a small divisor,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmc_mod_unit import gmc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mod_req_t req,
  output mod_rsp_t rsp
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [RAND_W-1:0]    sh_r, sh_nxt;
  logic [MOD_DIV_W-1:0] div_r, div_nxt;
  logic [MOD_REM_W-1:0] rem_r, rem_nxt;
  logic [BIT_CNT_W-1:0] bit_r, bit_nxt;
  logic [MOD_DIV_W-1:0] partial;
  logic [MOD_DIV_W-1:0] trial;

  assign partial = {rem_r, sh_r[RAND_W-1]};
  assign trial   = (partial >= div_r) ? (partial - div_r) : partial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh_nxt   = sh_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    bit_nxt  = bit_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      sh_nxt   = req.dividend;
      div_nxt  = req.divisor;
      rem_nxt  = '0;
      bit_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = MOD_REM_W'(trial);
      sh_nxt  = sh_r << 1;
      bit_nxt = bit_r + BIT_CNT_W'(1);
      if (bit_r == BIT_CNT_W'(RAND_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

[rtl/gmc_seq.sv]
// ----------------------------------------------------------------------------
// Grid maze carver sequencer
// Holds the cell store and the cell stack and steps each command through
// single-port reads and writes, using the remainder unit for the carve pick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gmc_seq import gmc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  gmc_in_if.sink           in_if,
  gmc_out_if.source        out_if,
  input  dim_t             eff_w,
  input  dim_t             eff_h,
  output mod_req_t         mod_req,
  input  mod_rsp_t         mod_rsp,
  output cnt_t             stack_cnt
);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RD    = 5'd2;
  localparam logic [4:0] S_RDO   = 5'd3;
  localparam logic [4:0] S_XRD   = 5'd4;
  localparam logic [4:0] S_XCHK  = 5'd5;
  localparam logic [4:0] S_XNRD  = 5'd6;
  localparam logic [4:0] S_XNWR  = 5'd7;
  localparam logic [4:0] S_D0RD  = 5'd8;
  localparam logic [4:0] S_D0WR  = 5'd9;
  localparam logic [4:0] S_D1RD  = 5'd10;
  localparam logic [4:0] S_D1WR  = 5'd11;
  localparam logic [4:0] S_POP   = 5'd12;
  localparam logic [4:0] S_POPD  = 5'd13;
  localparam logic [4:0] S_SCAN  = 5'd14;
  localparam logic [4:0] S_SCANE = 5'd15;
  localparam logic [4:0] S_MOD   = 5'd16;
  localparam logic [4:0] S_MODW  = 5'd17;
  localparam logic [4:0] S_CWR   = 5'd18;
  localparam logic [4:0] S_NWR   = 5'd19;
  localparam logic [4:0] S_START = 5'd20;

  typedef struct packed {
    logic ok;
    pos_t pos;
  } nb_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [DIR_W-1:0]    dir;
    logic [WALL_W-1:0]   walls;
    logic                vis;
  } out_t;

  function automatic nb_t nb_of(pos_t p, logic [DIR_W-1:0] d, dim_t w, dim_t h);
    cmp_t r;
    cmp_t c;
    cmp_t nr;
    cmp_t nc;
    nb_t  res;
    r      = CMP_W'(p.row);
    c      = CMP_W'(p.col);
    nr     = r;
    nc     = c;
    res.ok = 1'b1;
    case (d)
      DIR_UP: begin
        res.ok = (r != '0);
        nr     = r - CMP_W'(1);
      end
      DIR_DOWN: begin
        nr = r + CMP_W'(1);
      end
      DIR_LEFT: begin
        res.ok = (c != '0);
        nc     = c - CMP_W'(1);
      end
      default: begin
        nc = c + CMP_W'(1);
      end
    endcase
    res.ok      = res.ok && (nr < CMP_W'(h)) && (nc < CMP_W'(w));
    res.pos.row = ROW_W'(nr);
    res.pos.col = COL_W'(nc);
    return res;
  endfunction

  function automatic cell_t clear_wall(cell_t c, logic [DIR_W-1:0] d, logic mark);
    cell_t res;
    res         = c;
    res.walls   = c.walls & ~(WALL_W'(1) << d);
    res.visited = c.visited | mark;
    return res;
  endfunction

  function automatic out_t mk_out(logic [STATUS_W-1:0] st, logic [POS_W-1:0] r,
                                  logic [POS_W-1:0] c, logic [DIR_W-1:0] d,
                                  logic [WALL_W-1:0] w, logic v);
    out_t o;
    o.status = st;
    o.row    = r;
    o.col    = c;
    o.dir    = d;
    o.walls  = w;
    o.vis    = v;
    return o;
  endfunction

  cell_t cell_mem [CELLS];
  pos_t  stk_mem [CELLS];
  cell_t rd_data_r;
  pos_t  stk_rd_r;

  logic  mem_we;
  addr_t mem_wa;
  cell_t mem_wd;
  addr_t mem_ra;
  logic  stk_we;
  addr_t stk_wa;
  pos_t  stk_wd;
  addr_t stk_ra;

  logic [4:0]        state_r, state_nxt;
  logic [POS_W-1:0]  row_r, row_nxt;
  logic [POS_W-1:0]  col_r, col_nxt;
  logic [RAND_W-1:0] rnd_r, rnd_nxt;
  pos_t              cur_r, cur_nxt;
  cnt_t              cnt_r, cnt_nxt;
  logic [2:0]        k_r, k_nxt;
  logic [2:0]        kd_r, kd_nxt;
  logic              kv_r, kv_nxt;
  cell_t             cell_d_r, cell_d_nxt;
  cell_t             nbd_r [4];
  cell_t             nbd_nxt [4];
  logic [3:0]        cand_r, cand_nxt;
  logic [DIR_W-1:0]  pick_r, pick_nxt;
  addr_t             clr_r, clr_nxt;
  logic              clr_start_r, clr_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;

  nb_t               cur_nb [4];
  logic [3:0]        cand_c;
  logic [2:0]        ncand;
  logic [2:0]        seen;
  logic [DIR_W-1:0]  pick_sel;
  pos_t              in_pos;
  addr_t             in_addr;
  nb_t               x_nb;
  pos_t              last_pos;
  logic              in_bad;
  logic              accept;
  logic              push_ok;

  assign in_pos.row  = ROW_W'(row_r);
  assign in_pos.col  = COL_W'(col_r);
  assign in_addr     = cell_addr(in_pos);
  assign x_nb        = nb_of(in_pos, rnd_r[DIR_W-1:0], eff_w, eff_h);
  assign last_pos.row = ROW_W'(eff_h - DIM_W'(1));
  assign last_pos.col = COL_W'(eff_w - DIM_W'(1));
  assign in_bad      = (CMP_W'(in_if.cell_row) >= CMP_W'(eff_h)) ||
                       (CMP_W'(in_if.cell_col) >= CMP_W'(eff_w));
  assign accept      = in_if.valid && in_if.ready;
  assign push_ok     = (cnt_r < CNT_W'(CELLS));

  always_comb begin
    ncand = '0;
    for (int d = 0; d < 4; d++) begin
      cur_nb[d] = nb_of(cur_r, DIR_W'(d), eff_w, eff_h);
      cand_c[d] = cur_nb[d].ok && !nbd_r[d].visited;
      ncand     = ncand + {2'b00, cand_c[d]};
    end
  end

  always_comb begin
    seen     = '0;
    pick_sel = DIR_UP;
    for (int d = 0; d < 4; d++) begin
      if (cand_r[d]) begin
        if (seen == {1'b0, mod_rsp.rem}) begin
          pick_sel = DIR_W'(d);
        end
        seen = seen + 3'd1;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    rnd_nxt       = rnd_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    k_nxt         = k_r;
    kd_nxt        = kd_r;
    kv_nxt        = kv_r;
    cell_d_nxt    = cell_d_r;
    nbd_nxt       = nbd_r;
    cand_nxt      = cand_r;
    pick_nxt      = pick_r;
    clr_nxt       = clr_r;
    clr_start_nxt = clr_start_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_ra        = '0;
    stk_we        = 1'b0;
    stk_wa        = '0;
    stk_wd        = '0;
    stk_ra        = '0;
    mod_req       = '0;

    if ((state_r == S_SCAN || state_r == S_SCANE) && kv_r) begin
      if (kd_r == 3'd0) begin
        cell_d_nxt = rd_data_r;
      end else begin
        nbd_nxt[2'(kd_r - 3'd1)] = rd_data_r;
      end
    end

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        mem_wd  = '{visited: 1'b0, walls: WALLS_ALL};
        clr_nxt = clr_r + ADDR_W'(1);
        if (clr_r == ADDR_W'(CELLS - 1)) begin
          state_nxt     = clr_start_r ? S_START : S_IDLE;
          clr_start_nxt = 1'b0;
        end
      end
      S_IDLE: begin
        if (accept) begin
          row_nxt = in_if.cell_row;
          col_nxt = in_if.cell_col;
          rnd_nxt = in_if.rand_value;
          if (in_if.cmd == CMD_CARVE) begin
            state_nxt = (cnt_r == '0) ? S_D0RD : S_POP;
          end else if (in_bad) begin
            out_valid_nxt = 1'b1;
            out_nxt = mk_out(ST_BAD, in_if.cell_row, in_if.cell_col, DIR_UP, '0, 1'b0);
          end else begin
            case (in_if.cmd)
              CMD_START: begin
                state_nxt     = S_CLEAR;
                clr_nxt       = '0;
                clr_start_nxt = 1'b1;
                cnt_nxt       = '0;
              end
              CMD_REMOVE: state_nxt = S_XRD;
              CMD_READ:   state_nxt = S_RD;
              default:    state_nxt = S_IDLE;
            endcase
          end
        end
      end
      S_START: begin
        mem_we        = 1'b1;
        mem_wa        = in_addr;
        mem_wd        = '{visited: 1'b1, walls: WALLS_ALL};
        stk_we        = 1'b1;
        stk_wa        = '0;
        stk_wd        = in_pos;
        cnt_nxt       = CNT_W'(1);
        out_valid_nxt = 1'b1;
        out_nxt       = mk_out(ST_STARTED, row_r, col_r, DIR_UP, WALLS_ALL, 1'b1);
        state_nxt     = S_IDLE;
      end
      S_RD: begin
        mem_ra    = in_addr;
        state_nxt = S_RDO;
      end
      S_RDO: begin
        out_valid_nxt = 1'b1;
        out_nxt = mk_out(ST_READ, row_r, col_r, DIR_UP, rd_data_r.walls, rd_data_r.visited);
        state_nxt = S_IDLE;
      end
      S_XRD: begin
        mem_ra    = in_addr;
        state_nxt = S_XCHK;
      end
      S_XCHK: begin
        if (rd_data_r.walls[rnd_r[DIR_W-1:0]]) begin
          cell_d_nxt = clear_wall(rd_data_r, rnd_r[DIR_W-1:0], 1'b0);
          mem_we     = 1'b1;
          mem_wa     = in_addr;
          mem_wd     = cell_d_nxt;
          if (x_nb.ok) begin
            state_nxt = S_XNRD;
          end else begin
            out_valid_nxt = 1'b1;
            out_nxt = mk_out(ST_REMOVED, row_r, col_r, rnd_r[DIR_W-1:0],
                             cell_d_nxt.walls, cell_d_nxt.visited);
            state_nxt = S_IDLE;
          end
        end else begin
          out_valid_nxt = 1'b1;
          out_nxt = mk_out(ST_OPEN, row_r, col_r, rnd_r[DIR_W-1:0],
                           rd_data_r.walls, rd_data_r.visited);
          state_nxt = S_IDLE;
        end
      end
      S_XNRD: begin
        mem_ra    = cell_addr(x_nb.pos);
        state_nxt = S_XNWR;
      end
      S_XNWR: begin
        mem_we        = 1'b1;
        mem_wa        = cell_addr(x_nb.pos);
        mem_wd        = clear_wall(rd_data_r, opposite(rnd_r[DIR_W-1:0]), 1'b0);
        out_valid_nxt = 1'b1;
        out_nxt = mk_out(ST_REMOVED, row_r, col_r, rnd_r[DIR_W-1:0],
                         cell_d_r.walls, cell_d_r.visited);
        state_nxt = S_IDLE;
      end
      S_D0RD: begin
        mem_ra    = '0;
        state_nxt = S_D0WR;
      end
      S_D0WR: begin
        mem_we    = 1'b1;
        mem_wa    = '0;
        mem_wd    = clear_wall(rd_data_r, LEFT, 1'b0);
        state_nxt = S_D1RD;
      end
      S_D1RD: begin
        mem_ra    = cell_addr(last_pos);
        state_nxt = S_D1WR;
      end
      S_D1WR: begin
        mem_we        = 1'b1;
        mem_wa        = cell_addr(last_pos);
        mem_wd        = clear_wall(rd_data_r, DOWN, 1'b0);
        out_valid_nxt = 1'b1;
        out_nxt = mk_out(ST_DONE, POS_W'(last_pos.row), POS_W'(last_pos.col), DOWN,
                         mem_wd.walls, mem_wd.visited);
        state_nxt = S_IDLE;
      end
      S_POP: begin
        stk_ra    = ADDR_W'(cnt_r - CNT_W'(1));
        cnt_nxt   = cnt_r - CNT_W'(1);
        state_nxt = S_POPD;
      end
      S_POPD: begin
        cur_nxt   = stk_rd_r;
        k_nxt     = '0;
        kv_nxt    = 1'b0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (k_r == 3'd0) begin
          mem_ra = cell_addr(cur_r);
        end else begin
          mem_ra = cell_addr(cur_nb[2'(k_r - 3'd1)].pos);
        end
        kv_nxt = 1'b1;
        kd_nxt = k_r;
        k_nxt  = k_r + 3'd1;
        if (k_r == 3'd4) begin
          state_nxt = S_SCANE;
        end
      end
      S_SCANE: begin
        kv_nxt    = 1'b0;
        state_nxt = S_MOD;
      end
      S_MOD: begin
        cand_nxt = cand_c;
        if (ncand == 3'd0) begin
          out_valid_nxt = 1'b1;
          out_nxt = mk_out(ST_DEAD, POS_W'(cur_r.row), POS_W'(cur_r.col), DIR_UP,
                           cell_d_r.walls, cell_d_r.visited);
          state_nxt = S_IDLE;
        end else begin
          mod_req.start    = 1'b1;
          mod_req.dividend = rnd_r;
          mod_req.divisor  = ncand;
          state_nxt        = S_MODW;
        end
      end
      S_MODW: begin
        if (mod_rsp.done) begin
          pick_nxt  = pick_sel;
          state_nxt = S_CWR;
        end
      end
      S_CWR: begin
        cell_d_nxt = clear_wall(cell_d_r, pick_r, 1'b1);
        mem_we     = 1'b1;
        mem_wa     = cell_addr(cur_r);
        mem_wd     = cell_d_nxt;
        if (push_ok) begin
          stk_we  = 1'b1;
          stk_wa  = ADDR_W'(cnt_r);
          stk_wd  = cur_r;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        state_nxt = S_NWR;
      end
      S_NWR: begin
        mem_we = 1'b1;
        mem_wa = cell_addr(cur_nb[pick_r].pos);
        mem_wd = clear_wall(nbd_r[pick_r], opposite(pick_r), 1'b1);
        if (push_ok) begin
          stk_we  = 1'b1;
          stk_wa  = ADDR_W'(cnt_r);
          stk_wd  = cur_nb[pick_r].pos;
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        out_valid_nxt = 1'b1;
        out_nxt = mk_out(ST_CARVED, POS_W'(cur_r.row), POS_W'(cur_r.col), pick_r,
                         cell_d_r.walls, 1'b1);
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= cell_mem[mem_ra];
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      k_r         <= '0;
      kd_r        <= '0;
      kv_r        <= 1'b0;
      clr_r       <= '0;
      clr_start_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      k_r         <= k_nxt;
      kd_r        <= kd_nxt;
      kv_r        <= kv_nxt;
      clr_r       <= clr_nxt;
      clr_start_r <= clr_start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r    <= row_nxt;
    col_r    <= col_nxt;
    rnd_r    <= rnd_nxt;
    cur_r    <= cur_nxt;
    cell_d_r <= cell_d_nxt;
    nbd_r    <= nbd_nxt;
    cand_r   <= cand_nxt;
    pick_r   <= pick_nxt;
    out_r    <= out_nxt;
  end

  assign in_if.ready      = (state_r == S_IDLE) && !out_valid_r;
  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_r.status;
  assign out_if.out_row   = out_r.row;
  assign out_if.out_col   = out_r.col;
  assign out_if.direction = out_r.dir;
  assign out_if.wall_bits = out_r.walls;
  assign out_if.visited   = out_r.vis;
  assign stack_cnt        = cnt_r;

endmodule

[rtl/grid_maze_carver_core.sv]
// ----------------------------------------------------------------------------
// Grid maze carver core
// A carve step makes five store reads and then runs the serial remainder unit,
// unless the cell is a dead end; a start with good coordinates first sweeps the
// whole cell store. Throughput: one item at a time; the next beat is taken once
// the result beat has left. Reset (rst_n low, synchronous) runs a clearing pass
// over the whole cell store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_maze_carver_core import gmc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  gmc_in_if.sink    in_if,
  gmc_out_if.source out_if,
  gmc_cfg_if.sink   cfg_if
);

  function automatic dim_t clamp_dim(logic [CFG_DATA_W-1:0] v, dim_t maxv);
    dim_t res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (CMP_W'(v) > CMP_W'(maxv)) begin
      res = maxv;
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  logic [CFG_DATA_W-1:0] gw_r, gw_nxt;
  logic [CFG_DATA_W-1:0] gh_r, gh_nxt;
  dim_t                  eff_w;
  dim_t                  eff_h;
  mod_req_t              mod_req;
  mod_rsp_t              mod_rsp;
  cnt_t                  stack_cnt;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    gw_nxt = gw_r;
    gh_nxt = gh_r;
    if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_GRID_WIDTH:  gw_nxt = cfg_if.data;
        REG_GRID_HEIGHT: gh_nxt = cfg_if.data;
        default: begin
          gw_nxt = gw_r;
          gh_nxt = gh_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= GRID_RESET;
      gh_r <= GRID_RESET;
    end else begin
      gw_r <= gw_nxt;
      gh_r <= gh_nxt;
    end
  end

  assign eff_w = clamp_dim(gw_r, DIM_W'(MAX_COLS));
  assign eff_h = clamp_dim(gh_r, DIM_W'(MAX_ROWS));

  gmc_mod_unit u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  gmc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .eff_w     (eff_w),
    .eff_h     (eff_h),
    .mod_req   (mod_req),
    .mod_rsp   (mod_rsp),
    .stack_cnt (stack_cnt)
  );

`ifndef SYNTHESIS
  a_accept_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !out_if.valid)
    else $error("command beat taken while a result beat is pending");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |=> !in_if.ready)
    else $error("ready stayed high after a command beat");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stack_cnt <= CNT_W'(CELLS))
    else $error("cell stack count beyond its depth");
`endif

endmodule

[bench/grid_maze_carver_core_tb.sv]
// ----------------------------------------------------------------------------
// Grid maze carver core testbench
// Drives start, carve, wall removal and read commands into the core and
// checks every result beat against a cycle-free shadow of the cell grid, the
// visited marks and the cell stack. A short directed part covers the empty
// stack, border walls, already open walls, bad coordinates and popped cells
// that lie outside a shrunken grid. Random carving sessions follow over many
// grid sizes, with idle gaps on both channels and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_maze_carver_core_tb;
  import gmc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int MAX_GAP        = 20;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic [DIR_W-1:0]    dir;
    logic [WALL_W-1:0]   walls;
    logic                vis;
  } maze_result_t;

  class maze_scoreboard;
    logic [WALL_W-1:0]     walls [CELLS];
    logic                  vis [CELLS];
    addr_t                 cell_stack [CELLS];
    int                    depth;
    logic [CFG_DATA_W-1:0] reg_width;
    logic [CFG_DATA_W-1:0] reg_height;
    maze_result_t          pending_results [$];
    int                    errors;
    int                    status_seen [8];

    function new();
      clear_grid();
      depth      = 0;
      reg_width  = GRID_RESET;
      reg_height = GRID_RESET;
      errors     = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void clear_grid();
      foreach (walls[i]) begin
        walls[i] = WALLS_ALL;
        vis[i]   = 1'b0;
      end
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_GRID_WIDTH) begin
        reg_width = val;
      end else begin
        reg_height = val;
      end
    endfunction

    function int span(logic [CFG_DATA_W-1:0] v, int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
    endfunction

    function void push_cell(int idx);
      if (depth < CELLS) begin
        cell_stack[depth] = addr_t'(idx);
        depth++;
      end
    endfunction

    function bit step_to(int r, int c, logic [DIR_W-1:0] d, output int nr, output int nc);
      int w;
      int h;
      w  = span(reg_width, MAX_COLS);
      h  = span(reg_height, MAX_ROWS);
      nr = r;
      nc = c;
      case (d)
        DIR_UP: begin
          if (r == 0) return 1'b0;
          nr = r - 1;
        end
        DIR_DOWN: nr = r + 1;
        DIR_LEFT: begin
          if (c == 0) return 1'b0;
          nc = c - 1;
        end
        default: nc = c + 1;
      endcase
      return (nr < h) && (nc < w);
    endfunction

    function void predict_cmd(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] row,
                              logic [POS_W-1:0] col, logic [RAND_W-1:0] rnd);
      maze_result_t     e;
      int               w;
      int               h;
      int               cell_idx;
      int               r;
      int               c;
      int               nr;
      int               nc;
      int               nb;
      int               cnt;
      int               d;
      logic [DIR_W-1:0] cand [4];
      logic [DIR_W-1:0] pick;
      w = span(reg_width, MAX_COLS);
      h = span(reg_height, MAX_ROWS);
      e = '0;
      if (cmd == CMD_CARVE) begin
        if (depth == 0) begin
          cell_idx = (h - 1) * MAX_COLS + (w - 1);
          walls[0][LEFT]        = 1'b0;
          walls[cell_idx][DOWN] = 1'b0;
          e.status = ST_DONE;
          e.row    = POS_W'(h - 1);
          e.col    = POS_W'(w - 1);
          e.dir    = DOWN;
          e.walls  = walls[cell_idx];
          e.vis    = vis[cell_idx];
        end else begin
          depth--;
          cell_idx = int'(cell_stack[depth]);
          r        = cell_idx / MAX_COLS;
          c        = cell_idx % MAX_COLS;
          cnt      = 0;
          for (d = 0; d < 4; d++) begin
            if (step_to(r, c, DIR_W'(d), nr, nc) && !vis[nr * MAX_COLS + nc]) begin
              cand[cnt] = DIR_W'(d);
              cnt++;
            end
          end
          e.row = POS_W'(r);
          e.col = POS_W'(c);
          if (cnt == 0) begin
            e.status = ST_DEAD;
            e.dir    = DIR_UP;
            e.walls  = walls[cell_idx];
            e.vis    = vis[cell_idx];
          end else begin
            pick = cand[int'(rnd) % cnt];
            void'(step_to(r, c, pick, nr, nc));
            nb = nr * MAX_COLS + nc;
            walls[cell_idx][pick]   = 1'b0;
            vis[cell_idx]           = 1'b1;
            walls[nb][pick ^ 2'b01] = 1'b0;
            vis[nb]                 = 1'b1;
            push_cell(cell_idx);
            push_cell(nb);
            e.status = ST_CARVED;
            e.dir    = pick;
            e.walls  = walls[cell_idx];
            e.vis    = 1'b1;
          end
        end
      end else if (int'(row) >= h || int'(col) >= w) begin
        e.status = ST_BAD;
        e.row    = row;
        e.col    = col;
      end else begin
        cell_idx = int'(row) * MAX_COLS + int'(col);
        e.row    = row;
        e.col    = col;
        case (cmd)
          CMD_START: begin
            clear_grid();
            depth         = 0;
            vis[cell_idx] = 1'b1;
            push_cell(cell_idx);
            e.status = ST_STARTED;
            e.dir    = DIR_UP;
          end
          CMD_REMOVE: begin
            pick  = rnd[DIR_W-1:0];
            e.dir = pick;
            if (walls[cell_idx][pick]) begin
              walls[cell_idx][pick] = 1'b0;
              if (step_to(int'(row), int'(col), pick, nr, nc)) begin
                walls[nr * MAX_COLS + nc][pick ^ 2'b01] = 1'b0;
              end
              e.status = ST_REMOVED;
            end else begin
              e.status = ST_OPEN;
            end
          end
          default: begin
            e.status = ST_READ;
            e.dir    = DIR_UP;
          end
        endcase
        e.walls = walls[cell_idx];
        e.vis   = vis[cell_idx];
      end
      pending_results.insert(pending_results.size(), e);
    endfunction

    function void compare_field(string name, int want, int got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(maze_result_t got);
      maze_result_t want;
      if (pending_results.size() == 0) begin
        $error("result beat arrived with no command outstanding");
        errors++;
        return;
      end
      want = pending_results.pop_front();
      status_seen[got.status]++;
      compare_field("status", want.status, got.status);
      compare_field("out_row", want.row, got.row);
      compare_field("out_col", want.col, got.col);
      compare_field("direction", want.dir, got.dir);
      compare_field("wall_bits", want.walls, got.walls);
      compare_field("visited", want.vis, got.vis);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  gmc_in_if  cmd_bus ();
  gmc_out_if res_bus ();
  gmc_cfg_if cfg_bus ();

  grid_maze_carver_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (cmd_bus),
    .out_if (res_bus),
    .cfg_if (cfg_bus)
  );

  maze_scoreboard sb;
  int             send_idle_pct = 26;
  int             recv_idle_pct = 70;
  bit             hold_output   = 1'b0;
  int             items_sent    = 0;
  int             grid_settings = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_cmd(input logic [CMD_W-1:0] cmd, input int row, input int col,
                          input logic [RAND_W-1:0] rnd);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      cmd_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_bus.valid      <= 1'b1;
    cmd_bus.cmd        <= cmd;
    cmd_bus.cell_row   <= POS_W'(row);
    cmd_bus.cell_col   <= POS_W'(col);
    cmd_bus.rand_value <= rnd;
    do @(posedge clk); while (!cmd_bus.ready);
    sb.predict_cmd(cmd, POS_W'(row), POS_W'(col), rnd);
    items_sent++;
  endtask

  task automatic wait_for_results();
    cmd_bus.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    logic [CFG_IDX_W-1:0] idx;
    for (int i = 0; i < 2; i++) begin
      idx = (i == 0) ? REG_GRID_WIDTH : REG_GRID_HEIGHT;
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= (i == 0) ? w : h;
      do @(posedge clk); while (!cfg_bus.ready);
      sb.write_reg(idx, (i == 0) ? w : h);
    end
    cfg_bus.valid <= 1'b0;
    grid_settings++;
  endtask

  task automatic send_noise();
    send_cmd(CMD_W'($urandom_range(3)), $urandom_range(31), $urandom_range(31),
             RAND_W'($urandom));
  endtask

  task automatic run_session();
    int w;
    int h;
    int cap;
    int steps;
    w = sb.span(sb.reg_width, MAX_COLS);
    h = sb.span(sb.reg_height, MAX_ROWS);
    if ($urandom_range(9) == 0) begin
      send_cmd(CMD_START, $urandom_range(31), $urandom_range(31), RAND_W'($urandom));
    end else begin
      send_cmd(CMD_START, $urandom_range(h - 1), $urandom_range(w - 1), RAND_W'($urandom));
    end
    cap = 2 * w * h + 2;
    if (cap > 150) cap = 150;
    for (steps = 0; steps < cap && sb.depth != 0; steps++) begin
      if ($urandom_range(99) < 10) begin
        send_noise();
      end else begin
        send_cmd(CMD_CARVE, $urandom_range(31), $urandom_range(31), RAND_W'($urandom));
      end
    end
    repeat ($urandom_range(2, 1)) begin
      send_cmd(CMD_CARVE, $urandom_range(31), $urandom_range(31), RAND_W'($urandom));
    end
    repeat ($urandom_range(6)) begin
      send_cmd(($urandom_range(1) == 0) ? CMD_REMOVE : CMD_READ, $urandom_range(h - 1),
               $urandom_range(w - 1), RAND_W'($urandom));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && res_bus.valid && res_bus.ready) begin
      sb.check_result('{status: res_bus.status, row: res_bus.out_row, col: res_bus.out_col,
                        dir: res_bus.direction, walls: res_bus.wall_bits,
                        vis: res_bus.visited});
    end
  end

  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        res_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready) ||
          (cfg_bus.valid && cfg_bus.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int           directed_count;
    int           w;
    int           h;
    int           wlist [8] = '{1, 0, 32, 63, 2, 32, 33, 1};
    int           hlist [8] = '{1, 0, 32, 63, 32, 2, 1, 40};
    int           phase;
    string        names [8] = '{"started", "carved", "dead end", "done", "removed",
                                "already open", "read", "bad coordinates"};
    string        tally;
    sb = new();
    rst_n              <= 1'b0;
    cmd_bus.valid      <= 1'b0;
    cmd_bus.cmd        <= CMD_READ;
    cmd_bus.cell_row   <= '0;
    cmd_bus.cell_col   <= '0;
    cmd_bus.rand_value <= '0;
    cfg_bus.valid      <= 1'b0;
    cfg_bus.index      <= REG_GRID_WIDTH;
    cfg_bus.data       <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    send_cmd(CMD_CARVE, 0, 0, 16'h0000);
    send_cmd(CMD_READ, 0, 0, 16'h0000);
    send_cmd(CMD_READ, 31, 31, 16'hFFFF);
    send_cmd(CMD_REMOVE, 0, 0, 16'h0000);
    send_cmd(CMD_REMOVE, 0, 0, 16'hFFFF);
    send_cmd(CMD_REMOVE, 0, 0, 16'h0004);
    send_cmd(CMD_START, 31, 31, 16'hFFFF);
    send_cmd(CMD_CARVE, 31, 31, 16'hFFFF);
    send_cmd(CMD_CARVE, 0, 0, 16'h0000);
    send_cmd(CMD_CARVE, 0, 0, 16'h8000);
    send_cmd(CMD_READ, 31, 30, 16'h0000);
    send_cmd(CMD_REMOVE, 31, 31, 16'h0001);
    send_cmd(CMD_START, 0, 0, 16'h0000);
    send_cmd(CMD_CARVE, 0, 0, 16'h5555);
    send_cmd(CMD_CARVE, 0, 0, 16'hAAAA);
    send_cmd(CMD_START, 20, 20, 16'h0000);
    send_cmd(CMD_CARVE, 0, 0, 16'h0003);
    wait_for_results();
    set_grid(6'd4, 6'd4);
    send_cmd(CMD_CARVE, 0, 0, 16'h0000);
    send_cmd(CMD_CARVE, 0, 0, 16'h0000);
    send_cmd(CMD_CARVE, 0, 0, 16'h0000);
    send_cmd(CMD_READ, 31, 31, 16'h0000);
    send_cmd(CMD_REMOVE, 0, 4, 16'h0003);
    send_cmd(CMD_START, 4, 0, 16'h0000);
    send_cmd(CMD_START, 3, 3, 16'h0000);
    directed_count = items_sent;

    phase = 0;
    while (items_sent - directed_count < RANDOM_ITEMS) begin
      wait_for_results();
      if (items_sent - directed_count < RANDOM_ITEMS / 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 70;
      end else if (items_sent - directed_count < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 70;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (phase < 8) begin
        w = wlist[phase];
        h = hlist[phase];
      end else begin
        w = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(8, 1);
        h = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(8, 1);
      end
      set_grid(CFG_DATA_W'(w), CFG_DATA_W'(h));
      if (phase == 1) hold_output = 1'b1;
      repeat ($urandom_range(2, 1)) run_session();
      phase++;
    end
    wait_for_results();

    tally = "";
    foreach (names[i]) tally = {tally, $sformatf(" %s %0d;", names[i], sb.status_seen[i])};
    $display("Ran %0d commands (%0d directed) over %0d grid settings.", items_sent,
             directed_count, grid_settings);
    $display("Result beats by status:%s", tally);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
